>>> design/tdfr_pkg.sv
// ----------------------------------------------------------------------------
// tdfr_pkg
// Shared types and constants for the table download frame receiver.
// ----------------------------------------------------------------------------
package tdfr_pkg;

    localparam logic [15:0] HEADER_WORD = 16'h1328;
    localparam logic [15:0] REPLY_CODE  = 16'h0003;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned ADDR_W = 7;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned CFG_W  = 7;
    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WELL_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WELL_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_OFS  = 3'd4;

    // command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_CW    = 3;

    // reply frame is three result transfers
    localparam logic [1:0] REPLY_LAST_BEAT = 2'd2;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REPLY  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_ACK   = 2'd0,  // header seen, no write
        OP_WRITE = 2'd1,  // frame word stored
        OP_REPLY = 2'd2,  // good checksum: store plus three reply words
        OP_ERROR = 2'd3   // bad length or bad checksum
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] word;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] mode;
        logic [WORD_W-1:0] table_id;
    } cmd_t;

endpackage

>>> design/table_download_frame_receiver.sv
// ----------------------------------------------------------------------------
// table_download_frame_receiver
// Receives length-prefixed table frames with an additive checksum, reports
// table memory writes, reply words and errors as a result stream.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while the command queue is not full;
//   a good frame's checksum word gives three result transfers, one per cycle
//   through the single output register while the output is not stalled.
// Path: each word's command is written to the queue, then to the output register.
// A four-entry command queue lets input and output stall independently.
// Reset: synchronous, clears parser state and queue, reloads config defaults.
// ----------------------------------------------------------------------------
module table_download_frame_receiver #(
    parameter int unsigned TABLE_WORDS = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [6:0]   cfg_data,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [15:0] rx_word
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // [15:0] out_word, [16] wr_en, [23:17] wr_addr,
                                    // [39:24] wr_data, [55:40] work_mode,
                                    // [71:56] table_id
    output logic         m_tlast,
    output logic [1:0]   m_tuser    // [1:0] out_kind
);

    logic            q_full, q_not_empty, q_push, q_pop;
    tdfr_pkg::cmd_t  q_push_cmd, q_head;

    tdfr_front #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .word_valid (s_tvalid),
        .word_in    (s_tdata),
        .queue_full (q_full),
        .word_ready (s_tready),
        .push       (q_push),
        .push_cmd   (q_push_cmd)
    );

    tdfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    tdfr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

>>> design/tdfr_front.sv
// ----------------------------------------------------------------------------
// tdfr_front
// Frame parser: holds configuration, tracks frame position, running sum and
// write pointer, and turns each frame word into one queue command.
// ----------------------------------------------------------------------------
module tdfr_front #(
    parameter int unsigned TABLE_WORDS = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tdfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tdfr_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              word_valid,
    input  logic [tdfr_pkg::WORD_W-1:0]       word_in,
    input  logic                              queue_full,
    output logic                              word_ready,
    output logic                              push,
    output tdfr_pkg::cmd_t                    push_cmd
);

    localparam int unsigned AW    = $clog2(TABLE_WORDS);
    localparam int unsigned EXT_W = (AW > tdfr_pkg::ADDR_W) ? AW : tdfr_pkg::ADDR_W;

    logic [tdfr_pkg::LEN_W-1:0] cal_len_reg, well_len_reg;
    logic [tdfr_pkg::ADDR_W-1:0] cal_base_reg, well_base_reg;
    logic [5:0]                 mode_ofs_reg;

    logic                        receiving_reg, receiving_next;
    logic [tdfr_pkg::LEN_W-1:0]  count_reg, count_next;
    logic [tdfr_pkg::LEN_W-1:0]  frame_len_reg, frame_len_next;
    logic [AW-1:0]               ptr_reg, ptr_next;
    logic [15:0]                 sum_reg, sum_next;
    logic [15:0]                 cand_reg, cand_next;
    logic [15:0]                 table_reg, table_next;
    logic [15:0]                 mode_reg, mode_next;

    logic                        accept;
    logic                        cal_hit, well_hit;
    logic [tdfr_pkg::ADDR_W-1:0] base_sel;
    logic [AW-1:0]               base_ptr;
    logic [AW-1:0]               ptr_after_base, ptr_after_cur;
    logic [EXT_W-1:0]            ptr_ext;
    logic [15:0]                 expect_sum;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] a);
        logic [31:0] s;
        s = 32'(a) + 32'd1;
        return (s == TABLE_WORDS) ? '0 : AW'(s);
    endfunction

    function automatic logic [tdfr_pkg::ADDR_W-1:0] port_addr(input logic [AW-1:0] a);
        logic [EXT_W-1:0] e;
        e = EXT_W'(a);
        return e[tdfr_pkg::ADDR_W-1:0];
    endfunction

    assign word_ready = !queue_full;
    assign accept     = word_valid && word_ready;

    // base is below 128, so one conditional subtract reduces it
    assign base_sel = cal_hit ? cal_base_reg : well_base_reg;
    assign base_ptr = (32'(base_sel) >= TABLE_WORDS)
                    ? AW'(32'(base_sel) - TABLE_WORDS) : AW'(32'(base_sel));
    assign ptr_after_base = inc_ptr(base_ptr);
    assign ptr_after_cur  = inc_ptr(ptr_reg);
    assign ptr_ext        = EXT_W'(ptr_reg);

    assign cal_hit  = (word_in >= 16'd3) && (word_in == 16'(cal_len_reg));
    assign well_hit = (word_in >= 16'd3) && (word_in == 16'(well_len_reg));
    assign expect_sum = sum_reg + tdfr_pkg::HEADER_WORD;

    always_comb begin
        receiving_next = receiving_reg;
        count_next     = count_reg;
        frame_len_next = frame_len_reg;
        ptr_next       = ptr_reg;
        sum_next       = sum_reg;
        cand_next      = cand_reg;
        table_next     = table_reg;
        mode_next      = mode_reg;
        push               = 1'b0;
        push_cmd.op        = tdfr_pkg::OP_ACK;
        push_cmd.word      = word_in;
        push_cmd.addr      = ptr_ext[tdfr_pkg::ADDR_W-1:0];
        push_cmd.mode      = mode_reg;
        push_cmd.table_id  = table_reg;

        if (accept) begin
            if (!receiving_reg) begin
                if (word_in == tdfr_pkg::HEADER_WORD) begin
                    receiving_next = 1'b1;
                    count_next     = 7'd1;
                    push           = 1'b1;
                    push_cmd.op    = tdfr_pkg::OP_ACK;
                end
            end else if (count_reg == 7'd1) begin
                push = 1'b1;
                if (cal_hit || well_hit) begin
                    frame_len_next = word_in[tdfr_pkg::LEN_W-1:0];
                    ptr_next       = ptr_after_base;
                    sum_next       = word_in;
                    cand_next      = mode_reg;
                    count_next     = 7'd2;
                    push_cmd.op    = tdfr_pkg::OP_WRITE;
                    push_cmd.addr  = port_addr(base_ptr);
                end else begin
                    receiving_next = 1'b0;
                    count_next     = '0;
                    push_cmd.op    = tdfr_pkg::OP_ERROR;
                end
            end else if (count_reg == frame_len_reg) begin
                receiving_next = 1'b0;
                count_next     = '0;
                push           = 1'b1;
                if (expect_sum == word_in) begin
                    mode_next     = cand_reg;
                    push_cmd.op   = tdfr_pkg::OP_REPLY;
                    push_cmd.mode = cand_reg;
                end else begin
                    push_cmd.op   = tdfr_pkg::OP_ERROR;
                end
            end else begin
                if (count_reg == 7'd2) begin
                    table_next = word_in;
                end else if (count_reg - 7'd1 == {1'b0, mode_ofs_reg}) begin
                    cand_next = word_in;
                end
                sum_next          = sum_reg + word_in;
                ptr_next          = ptr_after_cur;
                count_next        = count_reg + 7'd1;
                push              = 1'b1;
                push_cmd.op       = tdfr_pkg::OP_WRITE;
                push_cmd.table_id = table_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_len_reg   <= 7'd21;
            well_len_reg  <= 7'd59;
            cal_base_reg  <= 7'd2;
            well_base_reg <= 7'd23;
            mode_ofs_reg  <= 6'd5;
            receiving_reg <= 1'b0;
            count_reg     <= '0;
            frame_len_reg <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            cand_reg      <= '0;
            table_reg     <= '0;
            mode_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    tdfr_pkg::CFG_CAL_LEN:   cal_len_reg   <= cfg_data;
                    tdfr_pkg::CFG_WELL_LEN:  well_len_reg  <= cfg_data;
                    tdfr_pkg::CFG_CAL_BASE:  cal_base_reg  <= cfg_data;
                    tdfr_pkg::CFG_WELL_BASE: well_base_reg <= cfg_data;
                    tdfr_pkg::CFG_MODE_OFS:  mode_ofs_reg  <= cfg_data[5:0];
                    default: ;
                endcase
            end
            receiving_reg <= receiving_next;
            count_reg     <= count_next;
            frame_len_reg <= frame_len_next;
            ptr_reg       <= ptr_next;
            sum_reg       <= sum_next;
            cand_reg      <= cand_next;
            table_reg     <= table_next;
            mode_reg      <= mode_next;
        end
    end

endmodule

>>> design/tdfr_queue.sv
// ----------------------------------------------------------------------------
// tdfr_queue
// Small command FIFO between parser and result sequencer.
// ----------------------------------------------------------------------------
module tdfr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tdfr_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output tdfr_pkg::cmd_t  head
);

    tdfr_pkg::cmd_t                  entry_reg [tdfr_pkg::QUEUE_DEPTH];
    logic [tdfr_pkg::QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [tdfr_pkg::QUEUE_CW-1:0]   count_reg;
    logic                            do_push, do_pop;

    assign full      = (count_reg == tdfr_pkg::QUEUE_CW'(tdfr_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

>>> design/tdfr_back.sv
// ----------------------------------------------------------------------------
// tdfr_back
// Result sequencer: expands queued commands into result transfers and holds
// them in the output register until taken.
// ----------------------------------------------------------------------------
module tdfr_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    input  tdfr_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [71:0]     m_tdata,
    output logic            m_tlast,
    output logic [1:0]      m_tuser
);

    logic         valid_reg;
    logic [1:0]   beat_reg, beat_next;
    logic [15:0]  word_reg, word_next;
    logic         wr_en_reg, wr_en_next;
    logic [6:0]   addr_reg, addr_next;
    logic [15:0]  data_reg, data_next;
    logic [15:0]  mode_reg;
    logic [15:0]  table_reg;
    logic         last_reg, last_next;
    tdfr_pkg::kind_t kind_reg, kind_next;
    logic         load;

    assign load = cmd_valid && (!valid_reg || m_tready);

    always_comb begin
        beat_next  = beat_reg;
        word_next  = '0;
        wr_en_next = 1'b0;
        addr_next  = '0;
        data_next  = '0;
        last_next  = 1'b1;
        kind_next  = tdfr_pkg::KIND_ACCEPT;
        cmd_pop    = 1'b0;
        case (cmd.op)
            tdfr_pkg::OP_ACK: begin
                cmd_pop = load;
            end
            tdfr_pkg::OP_WRITE: begin
                wr_en_next = 1'b1;
                addr_next  = cmd.addr;
                data_next  = cmd.word;
                cmd_pop    = load;
            end
            tdfr_pkg::OP_ERROR: begin
                kind_next = tdfr_pkg::KIND_ERROR;
                word_next = cmd.word;
                cmd_pop   = load;
            end
            tdfr_pkg::OP_REPLY: begin
                kind_next = tdfr_pkg::KIND_REPLY;
                case (beat_reg)
                    2'd0: begin
                        // checksum word is stored with the first reply word
                        word_next  = tdfr_pkg::REPLY_CODE;
                        wr_en_next = 1'b1;
                        addr_next  = cmd.addr;
                        data_next  = cmd.word;
                        last_next  = 1'b0;
                    end
                    2'd1: begin
                        word_next = cmd.word;
                        last_next = 1'b0;
                    end
                    default: begin
                        word_next = tdfr_pkg::REPLY_CODE + cmd.word;
                    end
                endcase
                cmd_pop = load && (beat_reg == tdfr_pkg::REPLY_LAST_BEAT);
                if (load) begin
                    beat_next = (beat_reg == tdfr_pkg::REPLY_LAST_BEAT)
                              ? 2'd0 : beat_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end else begin
            beat_reg <= beat_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg  <= word_next;
            wr_en_reg <= wr_en_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            mode_reg  <= cmd.mode;
            table_reg <= cmd.table_id;
            last_reg  <= last_next;
            kind_reg  <= kind_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {table_reg, mode_reg, data_reg, addr_reg, wr_en_reg, word_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = kind_reg;

endmodule
